@@ hw/rtl/mnh_pkg.sv @@
// Package for the MIDI note harmonizer: field widths, register indexes and
// the command and status groups between controller and datapath.
// No dependencies.
package mnh_pkg;

  localparam int NUM_VOICES = 7;
  localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int CHAN_W   = 4;
  localparam int DRAW_W   = 7;
  localparam int OFF_W    = 8;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int INT_LO_W = 32;
  localparam int INT_HI_W = 24;

  localparam logic [DRAW_W-1:0] CHANCE_ALWAYS = 7'd100;
  localparam logic [DRAW_W-1:0] CHANCE_NEVER  = 7'd0;
  localparam logic [NOTE_W-1:0] NOTE_MAX      = 7'd127;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANCE   = 2'd0,
    REG_ORIGIN   = 2'd1,
    REG_INT_LOW  = 2'd2,
    REG_INT_HIGH = 2'd3
  } mnh_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic               load;       // latch the accepted note
    logic               take;       // make the current candidate the pending note
    logic               emit;       // push the pending note to the output register
    logic               emit_last;  // mark the pushed note as final
    logic [VOICE_W-1:0] voice;      // voice under inspection
  } mnh_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bypass;      // gate says bypass for the note on the input channel
    logic keep;        // current voice yields a new harmony note
    logic pend_valid;  // a note waits to be emitted
    logic out_free;    // output register can take a note this cycle
  } mnh_sts_t;

endpackage

@@ hw/rtl/mnh_if.sv @@
// Valid/ready channel interfaces for note input and note output.
// Depends on mnh_pkg.
interface mnh_in_if import mnh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NOTE_W-1:0] note_number;
  logic [VEL_W-1:0]  velocity;
  logic [CHAN_W-1:0] channel;
  logic [DRAW_W-1:0] random_draw;

  modport source (output valid, note_number, velocity, channel, random_draw,
                  input ready);
  modport sink   (input valid, note_number, velocity, channel, random_draw,
                  output ready);
endinterface

interface mnh_out_if import mnh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NOTE_W-1:0] out_note;
  logic [VEL_W-1:0]  out_velocity;
  logic [CHAN_W-1:0] out_channel;
  logic              last;

  modport source (output valid, out_note, out_velocity, out_channel, last,
                  input ready);
  modport sink   (input valid, out_note, out_velocity, out_channel, last,
                  output ready);
endinterface

@@ hw/rtl/mnh_dp.sv @@
// Harmonizer datapath: configuration registers, latched note, per-voice
// transpose and clamp, sent-note list, pending note and output register.
// Depends on mnh_pkg.
module mnh_dp import mnh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [NOTE_W-1:0]    in_note,
  input  logic [VEL_W-1:0]     in_vel,
  input  logic [CHAN_W-1:0]    in_chan,
  input  logic [DRAW_W-1:0]    in_draw,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [NOTE_W-1:0]    out_note,
  output logic [VEL_W-1:0]     out_vel,
  output logic [CHAN_W-1:0]    out_chan,
  output logic                 out_last,
  input  mnh_cmd_t             cmd,
  output mnh_sts_t             sts
);

  logic [DRAW_W-1:0]   chance_r;
  logic                origin_r;
  logic [INT_LO_W-1:0] int_lo_r;
  logic [INT_HI_W-1:0] int_hi_r;

  logic [NOTE_W-1:0]   note_r;
  logic [VEL_W-1:0]    vel_r;
  logic [CHAN_W-1:0]   chan_r;

  logic [NOTE_W-1:0]   pend_note_r;
  logic                pend_valid_r;
  logic [NOTE_W-1:0]   sent_note_r [NUM_VOICES];
  logic [NUM_VOICES-1:0] sent_vld_r;

  logic                out_valid_r;
  logic [NOTE_W-1:0]   out_note_r;
  logic [VEL_W-1:0]    out_vel_r;
  logic [CHAN_W-1:0]   out_chan_r;
  logic                out_last_r;

  logic [INT_LO_W+INT_HI_W-1:0] offs_all;
  logic [OFF_W-1:0]    offset;
  logic signed [NOTE_W+1:0] sum;
  logic [NOTE_W-1:0]   cand;
  logic                dup;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chance_r <= CHANCE_ALWAYS;
      origin_r <= 1'b1;
      int_lo_r <= '0;
      int_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (mnh_reg_t'(cfg_index))
        REG_CHANCE:   chance_r <= cfg_data[DRAW_W-1:0];
        REG_ORIGIN:   origin_r <= cfg_data[0];
        REG_INT_LOW:  int_lo_r <= cfg_data[INT_LO_W-1:0];
        REG_INT_HIGH: int_hi_r <= cfg_data[INT_HI_W-1:0];
        default: ;
      endcase
    end
  end

  // Gate the effect against the chance percentage
  assign sts.bypass = (chance_r != CHANCE_ALWAYS) &&
                      ((chance_r == CHANCE_NEVER) || (in_draw > chance_r));

  // Transpose and clamp the current voice
  assign offs_all = {int_hi_r, int_lo_r};
  assign offset   = offs_all[{cmd.voice, 3'b000} +: OFF_W];
  assign sum      = $signed({2'b00, note_r}) + $signed({offset[OFF_W-1], offset});

  always_comb begin
    if (sum[NOTE_W+1]) begin
      cand = '0;
    end else if (sum[NOTE_W]) begin
      cand = NOTE_MAX;
    end else begin
      cand = sum[NOTE_W-1:0];
    end
  end

  // Compare against harmony notes already sent for this note
  always_comb begin
    dup = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      dup = dup | (sent_vld_r[v] && (sent_note_r[v] == cand));
    end
  end

  assign sts.keep       = (offset != '0) && !dup;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Hold the note fields, sent list and pending note
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      sent_vld_r   <= '0;
    end else if (cmd.load) begin
      pend_valid_r <= sts.bypass || origin_r;
      sent_vld_r   <= '0;
    end else if (cmd.take) begin
      pend_valid_r          <= 1'b1;
      sent_vld_r[cmd.voice] <= 1'b1;
    end else if (cmd.emit) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      note_r      <= in_note;
      vel_r       <= in_vel;
      chan_r      <= in_chan;
      pend_note_r <= in_note;
    end else if (cmd.take) begin
      pend_note_r            <= cand;
      sent_note_r[cmd.voice] <= cand;
    end
  end

  // Output register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_note_r <= pend_note_r;
      out_vel_r  <= vel_r;
      out_chan_r <= chan_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_note  = out_note_r;
  assign out_vel   = out_vel_r;
  assign out_chan  = out_chan_r;
  assign out_last  = out_last_r;

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register is full");

  a_take_keep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> (sts.keep && !cmd.load))
    else $error("took a zero-offset or duplicate voice");

  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (sent_vld_r == '0))
    else $error("sent list not cleared on a new note");
`endif

endmodule

@@ hw/rtl/mnh_ctrl.sv @@
// Harmonizer controller: accepts a note, steps through the voices one per
// cycle unless stalled, issues take and emit commands. Depends on mnh_pkg.
module mnh_ctrl import mnh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mnh_sts_t sts,
  output mnh_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FLUSH
  } state_t;

  state_t             state_r, state_nxt;
  logic [VOICE_W-1:0] voice_r, voice_nxt;
  logic               stall;

  // A kept note must push the pending one out first
  assign stall = sts.keep && sts.pend_valid && !sts.out_free;

  always_comb begin
    state_nxt     = state_r;
    voice_nxt     = voice_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.take      = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_last = 1'b0;
    cmd.voice     = voice_r;
    unique case (state_r)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          voice_nxt = '0;
          state_nxt = sts.bypass ? FLUSH : SCAN;
        end
      end
      SCAN: begin
        if (!stall) begin
          cmd.take = sts.keep;
          cmd.emit = sts.keep && sts.pend_valid;
          if (voice_r == VOICE_W'(NUM_VOICES - 1)) begin
            state_nxt = FLUSH;
          end else begin
            voice_nxt = voice_r + 1'b1;
          end
        end
      end
      FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = IDLE;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  // Hold state and voice counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      voice_r <= '0;
    end else begin
      state_r <= state_nxt;
      voice_r <= voice_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN && stall) |=> (voice_r == $past(voice_r) && state_r == SCAN))
    else $error("voice advanced while stalled");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_last |=> (state_r == IDLE))
    else $error("final note emitted but controller not idle");
`endif

endmodule

@@ hw/rtl/midi_note_harmonizer.sv @@
// MIDI note harmonizer top level: one note in, up to eight notes out.
// A bypassed note skips the voice scan; otherwise the scan visits the 7 voices
// in order, and each result is pushed once a later one is found or at the end.
// A new note is taken only after the last one is finished, and the block waits
// while the output is stalled. Synchronous active-low reset restores
// chance 100, play_origin 1, all intervals off, and empties the output.
module midi_note_harmonizer import mnh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mnh_in_if.sink               in_ch,
  mnh_out_if.source            out_ch
);

  mnh_cmd_t cmd;
  mnh_sts_t sts;

  mnh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mnh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_note   (in_ch.note_number),
    .in_vel    (in_ch.velocity),
    .in_chan   (in_ch.channel),
    .in_draw   (in_ch.random_draw),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_note  (out_ch.out_note),
    .out_vel   (out_ch.out_velocity),
    .out_chan  (out_ch.out_channel),
    .out_last  (out_ch.last),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
